>>> rtl/nrdh_pkg.sv
package nrdh_pkg;

  localparam int MAX_DISCS = 64;
  localparam int SLOT_W    = $clog2(MAX_DISCS);
  localparam int COUNT_W   = 7;
  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic        [30:0] r;
  } disc_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_25 = 2'd1,
    SH_48 = 2'd2
  } shift_t;

endpackage

>>> rtl/nrdh_disc_table.sv
module nrdh_disc_table (
  input  logic                       clk,
  input  logic                       wen,
  input  logic [nrdh_pkg::SLOT_W-1:0] waddr,
  input  nrdh_pkg::disc_t            wdata,
  input  logic [nrdh_pkg::SLOT_W-1:0] raddr,
  output nrdh_pkg::disc_t            rdata
);

  nrdh_pkg::disc_t mem [nrdh_pkg::MAX_DISCS];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/nearest_ray_disc_hit.sv
// Nearest ray/disc intersection.
// Input channel (in_valid/in_stall): mode 0 loads one disc (centre, normal,
// radius) into slot disc_slot and gives no result; mode 1 queries a ray with
// eye point_* and direction vector_*, and gives one result beat.
// Output channel (out_valid/out_stall): hit, nearest_index, distance (UQ15.16).
// Config: cfg_wen/cfg_wdata write disc_count, the number of slots a query
// walks; values above 64 count as 64. Write only while the block is idle.
// A query walks the slots one at a time through one shared 33x33 multiplier
// and a one-bit-per-cycle divider; for each slot it fetches the disc, forms
// the two dot products, checks them, divides, runs the radius test and
// advances, and the result is written in S_FIN after the last slot. Slots
// that miss early (parallel ray, behind the eye) skip the divide and the
// radius test; a saturated distance skips the divide.
// in_stall is high while a query runs. The result waits in an output
// register; a new item is taken while it waits, and a following query holds
// its own result until the previous beat is taken.
// Reset (rst, synchronous) clears disc_count and control state; the disc
// table is not cleared and a query must only reach loaded slots.
module nearest_ray_disc_hit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [5:0]                       disc_slot,
  input  logic signed [31:0]               point_x,
  input  logic signed [31:0]               point_y,
  input  logic signed [31:0]               point_z,
  input  logic signed [31:0]               vector_x,
  input  logic signed [31:0]               vector_y,
  input  logic signed [31:0]               vector_z,
  input  logic [30:0]                      radius,
  input  logic                             cfg_wen,
  input  logic [nrdh_pkg::COUNT_W-1:0]     cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [5:0]                       nearest_index,
  output logic [30:0]                      distance
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FETCH = 13'b0000000000010,
    S_NUM   = 13'b0000000000100,
    S_DEN   = 13'b0000000001000,
    S_CHECK = 13'b0000000010000,
    S_SAT   = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_PROJ  = 13'b0000010000000,
    S_SQ    = 13'b0000100000000,
    S_RR    = 13'b0001000000000,
    S_CMP   = 13'b0010000000000,
    S_NEXT  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [nrdh_pkg::COUNT_W-1:0] disc_count;
  logic [nrdh_pkg::COUNT_W-1:0] lim;
  logic [nrdh_pkg::COUNT_W-1:0] idx;
  logic [nrdh_pkg::COUNT_W-1:0] idx_inc;

  logic signed [31:0] eye [3];
  logic signed [31:0] dir [3];

  nrdh_pkg::disc_t wdisc;
  nrdh_pkg::disc_t rd;

  logic signed [31:0] nv [3];
  logic signed [32:0] vv [3];

  logic [3:0]  j;
  logic [1:0]  k;
  logic        p;
  logic [4:0]  cnt;
  logic [1:0]  jk;
  logic [1:0]  sq_k;
  logic [1:0]  sq_s;

  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  prod;
  nrdh_pkg::shift_t    sh_sel;
  nrdh_pkg::shift_t    psh;
  logic signed [99:0]  prod_w;
  logic signed [99:0]  prod_sh;
  logic signed [99:0]  acc;
  logic signed [99:0]  acc_sum;

  logic signed [67:0]  num;
  logic signed [67:0]  den;
  logic [67:0]         num_mag;
  logic [67:0]         den_mag;
  logic [95:0]         rem;
  logic [95:0]         dsh;
  logic                ge;
  logic [30:0]         tq;
  logic [30:0]         tq_shift;

  logic signed [50:0]  q;
  logic [50:0]         q_mag;
  logic [47:0]         m [3];

  logic                found;
  logic [5:0]          best_i;
  logic [30:0]         best_t;

  assign in_stall = (state != S_IDLE);

  assign wdisc = '{cx: point_x, cy: point_y, cz: point_z,
                   nx: vector_x, ny: vector_y, nz: vector_z, r: radius};

  nrdh_disc_table u_table (
    .clk   (clk),
    .wen   (in_valid && !in_stall && !mode),
    .waddr (disc_slot),
    .wdata (wdisc),
    .raddr (idx[nrdh_pkg::SLOT_W-1:0]),
    .rdata (rd)
  );

  always_comb begin
    nv[0] = rd.nx;
    nv[1] = rd.ny;
    nv[2] = rd.nz;
    vv[0] = {rd.cx[31], rd.cx} - {eye[0][31], eye[0]};
    vv[1] = {rd.cy[31], rd.cy} - {eye[1][31], eye[1]};
    vv[2] = {rd.cz[31], rd.cz} - {eye[2][31], eye[2]};
  end

  always_comb begin
    jk = (j < 4'd3) ? j[1:0] : 2'd0;
    case (j)
      4'd0, 4'd1, 4'd2: sq_k = 2'd0;
      4'd3, 4'd4, 4'd5: sq_k = 2'd1;
      4'd6, 4'd7, 4'd8: sq_k = 2'd2;
      default:          sq_k = 2'd0;
    endcase
    case (j)
      4'd0, 4'd3, 4'd6: sq_s = 2'd0;
      4'd1, 4'd4, 4'd7: sq_s = 2'd1;
      4'd2, 4'd5, 4'd8: sq_s = 2'd2;
      default:          sq_s = 2'd3;
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    sh_sel = nrdh_pkg::SH_0;
    case (state)
      S_NUM: begin
        mul_a = {nv[jk][31], nv[jk]};
        mul_b = vv[jk];
      end
      S_DEN: begin
        mul_a = {nv[jk][31], nv[jk]};
        mul_b = {dir[jk][31], dir[jk]};
      end
      S_PROJ: begin
        mul_a = {dir[k][31], dir[k]};
        mul_b = {2'b00, tq};
      end
      S_SQ: begin
        case (sq_s)
          2'd0: begin
            mul_a  = {9'd0, m[sq_k][47:24]};
            mul_b  = {9'd0, m[sq_k][47:24]};
            sh_sel = nrdh_pkg::SH_48;
          end
          2'd1: begin
            mul_a  = {9'd0, m[sq_k][47:24]};
            mul_b  = {9'd0, m[sq_k][23:0]};
            sh_sel = nrdh_pkg::SH_25;
          end
          2'd2: begin
            mul_a = {9'd0, m[sq_k][23:0]};
            mul_b = {9'd0, m[sq_k][23:0]};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_RR: begin
        mul_a = {2'b00, rd.r};
        mul_b = {2'b00, rd.r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_w = 100'(prod);
    case (psh)
      nrdh_pkg::SH_25: prod_sh = prod_w <<< 25;
      nrdh_pkg::SH_48: prod_sh = prod_w <<< 48;
      default:         prod_sh = prod_w;
    endcase
    acc_sum  = acc + prod_sh;
    num_mag  = num[67] ? 68'(-num) : 68'(num);
    den_mag  = den[67] ? 68'(-den) : 68'(den);
    ge       = (rem >= dsh);
    tq_shift = {tq[29:0], ge};
    q        = 51'(prod >>> nrdh_pkg::FRAC_BITS) - 51'(vv[k]);
    q_mag    = q[50] ? 51'(-q) : 51'(q);
    idx_inc  = idx + 7'd1;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    psh  <= sh_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      disc_count    <= '0;
      lim           <= '0;
      idx           <= '0;
      j             <= '0;
      k             <= '0;
      p             <= 1'b0;
      cnt           <= '0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
      hit           <= 1'b0;
      nearest_index <= '0;
      distance      <= '0;
    end else begin
      if (cfg_wen) begin
        disc_count <= cfg_wdata;
      end
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && mode) begin
            eye[0] <= point_x;
            eye[1] <= point_y;
            eye[2] <= point_z;
            dir[0] <= vector_x;
            dir[1] <= vector_y;
            dir[2] <= vector_z;
            lim    <= (disc_count > 7'(nrdh_pkg::MAX_DISCS)) ?
                      7'(nrdh_pkg::MAX_DISCS) : disc_count;
            idx    <= '0;
            found  <= 1'b0;
            best_i <= '0;
            best_t <= '0;
            state  <= (disc_count == '0) ? S_FIN : S_FETCH;
          end
        end
        S_FETCH: begin
          j     <= '0;
          state <= S_NUM;
        end
        S_NUM: begin
          acc <= (j == 4'd0) ? '0 : acc_sum;
          if (j == 4'd3) begin
            num   <= acc_sum[67:0];
            j     <= '0;
            state <= S_DEN;
          end else begin
            j <= j + 4'd1;
          end
        end
        S_DEN: begin
          acc <= (j == 4'd0) ? '0 : acc_sum;
          if (j == 4'd3) begin
            den   <= acc_sum[67:0];
            j     <= '0;
            state <= S_CHECK;
          end else begin
            j <= j + 4'd1;
          end
        end
        S_CHECK: begin
          if (num == '0 || den == '0 || num[67] != den[67]) begin
            state <= S_NEXT;
          end else begin
            rem   <= 96'(num_mag) << nrdh_pkg::FRAC_BITS;
            dsh   <= 96'(den_mag) << 30;
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (rem >= {dsh[94:0], 1'b0}) begin
            tq    <= '1;
            k     <= '0;
            p     <= 1'b0;
            state <= S_PROJ;
          end else begin
            tq    <= '0;
            cnt   <= 5'd30;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          dsh <= dsh >> 1;
          tq  <= tq_shift;
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            k     <= '0;
            p     <= 1'b0;
            state <= (tq_shift == '0) ? S_NEXT : S_PROJ;
          end
        end
        S_PROJ: begin
          if (!p) begin
            p <= 1'b1;
          end else begin
            m[k] <= q_mag[47:0];
            p    <= 1'b0;
            if (k == 2'd2) begin
              j     <= '0;
              state <= S_SQ;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_SQ: begin
          acc <= (j == 4'd0) ? '0 : acc_sum;
          if (j == 4'd9) begin
            j     <= '0;
            state <= S_RR;
          end else begin
            j <= j + 4'd1;
          end
        end
        S_RR: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (acc <= 100'(prod) && (!found || tq < best_t)) begin
            found  <= 1'b1;
            best_t <= tq;
            best_i <= idx[5:0];
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          idx   <= idx_inc;
          state <= (idx_inc >= lim) ? S_FIN : S_FETCH;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            hit           <= found;
            nearest_index <= found ? best_i : '0;
            distance      <= found ? best_t : '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> nearest_index == '0 && distance == '0)
    else $error("miss result carries nonzero index or distance");

  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> distance != '0)
    else $error("hit result with zero distance");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> idx < lim)
    else $error("slot index past query limit");

  a_div_run: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && cnt != '0 |=> state == S_DIV)
    else $error("divider left early");
`endif

endmodule
